// File: hdl/cdd_pkg.sv
// Shared types and constants for the calendar date difference block.
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int YEAR_W       = 14;
  localparam int MONTH_W      = 4;
  localparam int DAY_W        = 5;
  localparam int COUNT_W      = 22;
  localparam int YEAR_MAX_DEF = 9999;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MULA,
    ST_MULB,
    ST_LEAP,
    ST_ORD,
    ST_DIFF
  } state_t;

  typedef struct packed {
    logic load;
    logic year;
    logic mula;
    logic mulb;
    logic leap;
    logic ord;
    logic diff;
    logic sel;
  } cmd_t;

endpackage

// File: hdl/cdd_ctrl.sv
// Sequencer for the calendar date difference block.
`timescale 1ns / 1ps

module cdd_ctrl
  import cdd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   sel;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_YEAR;
      ST_YEAR: state_next = ST_MULA;
      ST_MULA: state_next = ST_MULB;
      ST_MULB: state_next = ST_LEAP;
      ST_LEAP: state_next = ST_ORD;
      ST_ORD:  state_next = sel ? ST_DIFF : ST_YEAR;
      ST_DIFF: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.sel = sel;
    unique case (state)
      ST_IDLE: cmd.load = start;
      ST_YEAR: cmd.year = 1'b1;
      ST_MULA: cmd.mula = 1'b1;
      ST_MULB: cmd.mulb = 1'b1;
      ST_LEAP: cmd.leap = 1'b1;
      ST_ORD:  cmd.ord  = 1'b1;
      ST_DIFF: cmd.diff = 1'b1;
      default: cmd      = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DIFF);
      if (cmd.load) sel <= 1'b0;
      else if (cmd.ord) sel <= 1'b1;
    end
  end

endmodule

// File: hdl/cdd_datapath.sv
// Date normalisation, day ordinal and difference datapath.
`timescale 1ns / 1ps

module cdd_datapath
  import cdd_pkg::*;
#(
  parameter int YEAR_MAX = YEAR_MAX_DEF
) (
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic [YEAR_W-1:0]  first_year,
  input  logic [MONTH_W-1:0] first_month,
  input  logic [DAY_W-1:0]   first_day,
  input  logic [YEAR_W-1:0]  second_year,
  input  logic [MONTH_W-1:0] second_month,
  input  logic [DAY_W-1:0]   second_day,
  output logic [COUNT_W-1:0] day_count
);

  localparam int ORD_W     = 23;
  localparam int PROD_W    = 2 * YEAR_W;
  localparam int RECIP_100 = 10486;
  localparam int RECIP_SH  = 20;
  localparam int Q_W       = 8;
  localparam int LEAPS_W   = 13;
  localparam logic [ORD_W-1:0] COUNT_SAT = ORD_W'((1 << COUNT_W) - 1);

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  logic [YEAR_W-1:0]  y1, y2, yr;
  logic [MONTH_W-1:0] m1, m2, mon;
  logic [DAY_W-1:0]   d1, d2, day;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     q100x;
  logic [LEAPS_W-1:0] leaps;
  logic               leap;
  logic [ORD_W-1:0]   ord_a, ord_b;

  logic [YEAR_W-1:0]  y_sel, yr_m1;
  logic [Q_W-1:0]     q100y;
  logic [YEAR_W-1:0]  rem100;
  logic [MONTH_W-1:0] mon_n;
  logic [DAY_W-1:0]   mlen, day_n;
  logic [ORD_W-1:0]   ord, diff;

  assign y_sel  = cmd.sel ? y2 : y1;
  assign yr_m1  = yr - YEAR_W'(1);
  assign q100y  = prod[RECIP_SH +: Q_W];
  assign rem100 = yr - YEAR_W'(q100y) * YEAR_W'(100);
  assign mon_n  = (mon == '0 || mon > MONTH_W'(12)) ? MONTH_W'(1) : mon;

  always_comb begin
    case (mon_n)
      4'd2:                      mlen = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   mlen = DAY_W'(30);
      default:                   mlen = DAY_W'(31);
    endcase
  end

  assign day_n = (day == '0 || day > mlen) ? DAY_W'(1) : day;
  assign ord   = ORD_W'(yr) * ORD_W'(365) + ORD_W'(leaps) + ORD_W'(days_before(mon_n))
               + ORD_W'(day_n) - ORD_W'(1)
               + ORD_W'(leap && (mon_n > MONTH_W'(2)));
  assign diff  = (ord_a > ord_b) ? (ord_a - ord_b) : (ord_b - ord_a);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y1 <= first_year;
      m1 <= first_month;
      d1 <= first_day;
      y2 <= second_year;
      m2 <= second_month;
      d2 <= second_day;
    end
    if (cmd.year) begin
      if (y_sel == '0) yr <= YEAR_W'(1);
      else if (32'(y_sel) > 32'(YEAR_MAX)) yr <= YEAR_W'(YEAR_MAX);
      else yr <= y_sel;
      mon <= cmd.sel ? m2 : m1;
      day <= cmd.sel ? d2 : d1;
    end
    if (cmd.mula) prod <= PROD_W'(yr_m1) * PROD_W'(RECIP_100);
    if (cmd.mulb) begin
      q100x <= prod[RECIP_SH +: Q_W];
      prod  <= PROD_W'(yr) * PROD_W'(RECIP_100);
    end
    if (cmd.leap) begin
      leap  <= (yr[1:0] == 2'b00) && ((rem100 != '0) || (q100y[1:0] == 2'b00));
      leaps <= LEAPS_W'(yr_m1 >> 2) - LEAPS_W'(q100x) + LEAPS_W'(q100x >> 2)
             + LEAPS_W'(1);
    end
    if (cmd.ord) begin
      if (cmd.sel) ord_b <= ord;
      else ord_a <= ord;
    end
    if (cmd.diff) day_count <= (diff > COUNT_SAT) ? COUNT_SAT[COUNT_W-1:0] : diff[COUNT_W-1:0];
  end

endmodule

// File: hdl/calendar_date_difference_top.sv
// Top level of the calendar date difference block.
`timescale 1ns / 1ps
//
// Command channel: an item transfers at a rising edge with start high and busy low;
// the six date fields are sampled at that edge. busy rises at that same edge.
// Each date is clamped and normalised, then turned into a day ordinal over five
// steps of one shared sequence (load, two multiplies by the reciprocal of 100,
// leap test, ordinal sum); one more step subtracts and saturates.
// done is registered from the difference step, and day_count is valid
// while done is high, for exactly one cycle.
// A new start is taken in the done cycle; no start is taken while busy is high.
// day_count holds its value until the next result.
// Reset (rst, synchronous) returns the sequencer to idle and clears done.
// The receiver cannot stall: each result must be taken in its done cycle.

module calendar_date_difference_top
  import cdd_pkg::*;
#(
  parameter int YEAR_MAX = YEAR_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [YEAR_W-1:0]  first_year,
  input  logic [MONTH_W-1:0] first_month,
  input  logic [DAY_W-1:0]   first_day,
  input  logic [YEAR_W-1:0]  second_year,
  input  logic [MONTH_W-1:0] second_month,
  input  logic [DAY_W-1:0]   second_day,
  output logic               done,
  output logic [COUNT_W-1:0] day_count
);

  cmd_t cmd;

  cdd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  cdd_datapath #(
    .YEAR_MAX (YEAR_MAX)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .first_year   (first_year),
    .first_month  (first_month),
    .first_day    (first_day),
    .second_year  (second_year),
    .second_month (second_month),
    .second_day   (second_day),
    .day_count    (day_count)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while sequencer busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start the sequence");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("result strobe without a preceding sequence");

endmodule

// File: bench/tb_calendar_date_difference_top.sv
// Self-checking testbench for the calendar date difference block.
`timescale 1ns / 1ps

module tb_calendar_date_difference_top;
  import cdd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int COUNT_SAT  = (1 << COUNT_W) - 1;
  localparam int unsigned DAYS_BEFORE [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t first;
    date_t second;
  } date_pair_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [YEAR_W-1:0]  first_year = '0;
  logic [MONTH_W-1:0] first_month = '0;
  logic [DAY_W-1:0]   first_day = '0;
  logic [YEAR_W-1:0]  second_year = '0;
  logic [MONTH_W-1:0] second_month = '0;
  logic [DAY_W-1:0]   second_day = '0;
  logic               done;
  logic [COUNT_W-1:0] day_count;

  date_pair_t         pending_pairs[$];
  logic [COUNT_W-1:0] expected_counts[$];
  logic               accepted = 1'b0;
  int                 gap_left = 0;
  int                 calm_left = 0;
  int                 idle_cycles = 0;
  int                 error_count = 0;
  logic               timed_out = 1'b0;
  logic [COUNT_W-1:0] want_count;
  date_pair_t         next_pair;

  calendar_date_difference_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .first_year   (first_year),
    .first_month  (first_month),
    .first_day    (first_day),
    .second_year  (second_year),
    .second_month (second_month),
    .second_day   (second_day),
    .done         (done),
    .day_count    (day_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic int unsigned date_ordinal(date_t dt);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned ord;
    y = 32'(dt.year);
    m = 32'(dt.month);
    d = 32'(dt.day);
    if (y < 1) y = 1;
    if (y > YEAR_MAX_DEF) y = YEAR_MAX_DEF;
    if (m < 1 || m > 12) m = 1;
    if (d < 1 || d > month_days(y, m)) d = 1;
    ord = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    ord = ord + DAYS_BEFORE[m - 1] + d - 1;
    if (m > 2 && is_leap(y)) ord = ord + 1;
    return ord;
  endfunction

  function automatic logic [COUNT_W-1:0] days_apart(date_pair_t p);
    int unsigned a;
    int unsigned b;
    int unsigned diff;
    a = date_ordinal(p.first);
    b = date_ordinal(p.second);
    diff = (a > b) ? a - b : b - a;
    if (diff > COUNT_SAT) diff = COUNT_SAT;
    return diff[COUNT_W-1:0];
  endfunction

  function automatic date_t random_valid_date();
    date_t       dt;
    int unsigned y;
    int unsigned m;
    case ($urandom_range(0, 9))
      0: y = $urandom_range(1, 4);
      1: y = $urandom_range(YEAR_MAX_DEF - 3, YEAR_MAX_DEF);
      2: y = $urandom_range(1, 99) * 100;
      3: y = $urandom_range(1, 24) * 400;
      default: y = $urandom_range(1, YEAR_MAX_DEF);
    endcase
    m = $urandom_range(1, 12);
    dt.year  = YEAR_W'(y);
    dt.month = MONTH_W'(m);
    if ($urandom_range(0, 4) == 0) dt.day = DAY_W'(month_days(y, m));
    else dt.day = DAY_W'($urandom_range(1, month_days(y, m)));
    return dt;
  endfunction

  function automatic date_t random_raw_date();
    date_t dt;
    dt.year  = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
    dt.month = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
    dt.day   = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
    return dt;
  endfunction

  task automatic add_pair(int y1, int m1, int d1, int y2, int m2, int d2);
    date_pair_t p;
    p.first  = '{year: YEAR_W'(y1), month: MONTH_W'(m1), day: DAY_W'(d1)};
    p.second = '{year: YEAR_W'(y2), month: MONTH_W'(m2), day: DAY_W'(d2)};
    pending_pairs.push_back(p);
  endtask

  initial begin
    date_pair_t p;
    add_pair(2024, 5, 17, 2024, 5, 17);
    add_pair(1, 1, 1, 9999, 12, 31);
    add_pair(9999, 12, 31, 1, 1, 1);
    add_pair(0, 0, 0, 0, 0, 0);
    add_pair(16383, 15, 31, 1, 1, 1);
    add_pair(10000, 6, 15, 9999, 6, 15);
    add_pair(0, 3, 1, 1, 3, 1);
    add_pair(2023, 0, 10, 2023, 1, 10);
    add_pair(2023, 13, 10, 2023, 1, 10);
    add_pair(2023, 15, 5, 2023, 12, 5);
    add_pair(2023, 7, 0, 2023, 7, 1);
    add_pair(2023, 4, 31, 2023, 4, 30);
    add_pair(2000, 2, 29, 2000, 3, 1);
    add_pair(1900, 2, 29, 1900, 2, 28);
    add_pair(2024, 2, 29, 2023, 2, 28);
    add_pair(2023, 2, 29, 2023, 2, 1);
    add_pair(2024, 2, 30, 2024, 2, 1);
    add_pair(1999, 12, 31, 2000, 1, 1);
    add_pair(400, 2, 29, 401, 1, 1);
    add_pair(100, 2, 28, 100, 3, 1);
    add_pair(4, 2, 29, 4, 3, 1);
    add_pair(2024, 1, 31, 2024, 12, 31);
    add_pair(1, 1, 1, 1, 12, 31);
    repeat (650) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          p.first  = random_raw_date();
          p.second = ($urandom_range(0, 1) != 0) ? random_raw_date() : random_valid_date();
        end
        2, 3: begin
          p.first  = random_valid_date();
          p.second = random_valid_date();
          p.second.year = p.first.year;
          if (p.second.day > month_days(32'(p.second.year), 32'(p.second.month)))
            p.second.day = DAY_W'(month_days(32'(p.second.year), 32'(p.second.month)));
        end
        4: begin
          p.first  = random_valid_date();
          p.second = p.first;
        end
        default: begin
          p.first  = random_valid_date();
          p.second = random_valid_date();
        end
      endcase
      pending_pairs.push_back(p);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !accepted) begin
      // hold until the transfer completes
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_pairs.size() != 0) begin
      next_pair = pending_pairs.pop_front();
      first_year   <= next_pair.first.year;
      first_month  <= next_pair.first.month;
      first_day    <= next_pair.first.day;
      second_year  <= next_pair.second.year;
      second_month <= next_pair.second.month;
      second_day   <= next_pair.second.day;
      start <= 1'b1;
      if (calm_left != 0) begin
        calm_left = calm_left - 1;
        gap_left = 0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:2]:   begin calm_left = $urandom_range(10, 40); gap_left = 0; end
          [3:54]:  gap_left = 0;
          [55:89]: gap_left = $urandom_range(1, 6);
          default: gap_left = $urandom_range(8, 40);
        endcase
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      accepted <= 1'b0;
      idle_cycles <= 0;
    end else begin
      accepted <= start && !busy;
      if (start && !busy) begin
        expected_counts.push_back(days_apart('{
          first:  '{year: first_year, month: first_month, day: first_day},
          second: '{year: second_year, month: second_month, day: second_day}}));
      end
      if (done) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, day_count);
          error_count = error_count + 1;
        end else begin
          want_count = expected_counts.pop_front();
          if (day_count !== want_count) begin
            $display("%0t: day_count mismatch, expected %0d, actual %0d",
                     $time, want_count, day_count);
            error_count = error_count + 1;
          end
        end
      end
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) timed_out <= 1'b1;
      end
    end
  end

  initial begin
    @(negedge rst);
    while (!timed_out &&
           !(pending_pairs.size() == 0 && !start && expected_counts.size() == 0))
      @(posedge clk);
    if (!timed_out) repeat (24) @(posedge clk);
    if (error_count == 0 && !timed_out) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/cdd_pkg.sv
hdl/cdd_ctrl.sv
hdl/cdd_datapath.sv
hdl/calendar_date_difference_top.sv
bench/tb_calendar_date_difference_top.sv
